// ----- hdl/assert_macros.svh -----
// Assertion helpers used by the lock's top-level RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Whenever ante holds at a clock edge, cons must hold at the same edge.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// cond must never hold at a clock edge.
`define ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");

`endif

// ----- hdl/kcl_pkg.sv -----
package kcl_pkg;

    typedef logic [3:0] key_t;

    localparam key_t KEY_STAR = 4'd12;
    localparam key_t KEY_HASH = 4'd14;

    localparam logic [3:0] RESET_MAX_ATTEMPTS = 4'd3;

    // One result; the last field sits in the lowest bit.
    typedef struct packed {
        logic       in_change_mode;
        logic [2:0] entry_length;
        logic       code_changed;
        logic       change_entered;
        logic       wrong_code;
        logic       unlocked;
    } result_t;

    // Keypad index of a decimal digit.
    function automatic key_t digit_key(input logic [3:0] digit);
        key_t k;
        case (digit)
            4'd0:    k = 4'd13;
            4'd1:    k = 4'd0;
            4'd2:    k = 4'd1;
            4'd3:    k = 4'd2;
            4'd4:    k = 4'd4;
            4'd5:    k = 4'd5;
            4'd6:    k = 4'd6;
            4'd7:    k = 4'd8;
            4'd8:    k = 4'd9;
            4'd9:    k = 4'd10;
            default: k = 4'd0;
        endcase
        return k;
    endfunction

endpackage

// ----- hdl/kcl_core.sv -----
module kcl_core #(
    parameter int CODE_LENGTH = 6
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step_en,
    input  kcl_pkg::key_t    key,
    input  logic [3:0]       max_attempts,
    output kcl_pkg::result_t res
);

    localparam int CW = $clog2(CODE_LENGTH + 1);
    localparam int IW = (CODE_LENGTH > 1) ? $clog2(CODE_LENGTH) : 1;
    localparam logic [CW-1:0] FULL_COUNT = CW'(CODE_LENGTH);

    kcl_pkg::key_t stored_reg [CODE_LENGTH];
    kcl_pkg::key_t entry_reg  [CODE_LENGTH];

    logic [CW-1:0] count_reg, count_next;
    logic          change_reg, change_next;
    logic [3:0]    failure_reg, failure_next;
    logic [3:0]    failure_inc;
    logic          full, is_confirm, is_delete, do_append, do_store, match;
    logic [IW-1:0] wr_idx;
    logic [CW+2:0] count_ext;

    assign full       = (count_reg >= FULL_COUNT);
    assign is_confirm = (key == kcl_pkg::KEY_STAR) && full;
    assign is_delete  = !is_confirm && (key == kcl_pkg::KEY_HASH) && (count_reg != '0);
    assign do_append  = !is_confirm && !is_delete && !full;
    assign do_store   = is_confirm && change_reg;
    assign wr_idx     = count_reg[IW-1:0];
    assign failure_inc = failure_reg + 4'd1;

    always_comb
    begin
        match = 1'b1;
        for (int i = 0; i < CODE_LENGTH; i++)
        begin
            if (entry_reg[i] != stored_reg[i])
            begin
                match = 1'b0;
            end
        end
    end

    always_comb
    begin
        count_next   = count_reg;
        change_next  = change_reg;
        failure_next = failure_reg;
        res          = '0;
        if (is_confirm)
        begin
            count_next = '0;
            if (change_reg)
            begin
                change_next      = 1'b0;
                res.code_changed = 1'b1;
            end
            else if (match)
            begin
                res.unlocked = 1'b1;
            end
            else
            begin
                res.wrong_code = 1'b1;
                failure_next   = failure_inc;
                if (failure_inc >= max_attempts)
                begin
                    change_next        = 1'b1;
                    failure_next       = 4'd0;
                    res.change_entered = 1'b1;
                end
            end
        end
        else if (is_delete)
        begin
            count_next = count_reg - CW'(1);
        end
        else if (do_append)
        begin
            count_next = count_reg + CW'(1);
        end
        count_ext          = {3'b000, count_next};
        res.entry_length   = count_ext[2:0];
        res.in_change_mode = change_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            change_reg  <= 1'b0;
            failure_reg <= 4'd0;
        end
        else if (step_en)
        begin
            count_reg   <= count_next;
            change_reg  <= change_next;
            failure_reg <= failure_next;
        end
    end

    for (genvar g = 0; g < CODE_LENGTH; g++)
    begin : g_slot
        localparam int DIGIT = (g + 1) % 10;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                stored_reg[g] <= kcl_pkg::digit_key(4'(DIGIT));
            end
            else if (step_en && do_store)
            begin
                stored_reg[g] <= entry_reg[g];
            end
        end

        always_ff @(posedge clk)
        begin
            if (step_en && do_append && (wr_idx == IW'(g)))
            begin
                entry_reg[g] <= key;
            end
        end
    end

endmodule

// ----- hdl/keypad_code_lock.sv -----
// Keypad code lock: each request on the s_ side carries one key index of a 4x4 keypad
// (12 is '*' to confirm, 14 is '#' to delete) and yields exactly one result on the m_
// side with pulse flags for unlock, wrong code, entry into code-change mode and code
// stored, plus the current entry length and mode. A key passes through an input register
// and the compare-and-update logic into the result register, so a new key is
// taken every cycle while the result side keeps up; the result register is loaded when
// the core steps, which waits while a result is stalled. The user must write max_attempts
// through cfg_wr_en/cfg_wr_data only while idle; the block does not enforce this.
`include "assert_macros.svh"

module keypad_code_lock #(
    parameter int CODE_LENGTH = 6
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_wr_en,
    input  logic [3:0] cfg_wr_data,   // max_attempts
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,       // [3:0] key_code, [7:4] zero
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata        // [0] unlocked, [1] wrong_code, [2] change_entered,
                                      // [3] code_changed, [6:4] entry_length,
                                      // [7] in_change_mode
);

    logic             in_valid_reg;
    kcl_pkg::key_t    key_reg;
    logic             out_valid_reg;
    kcl_pkg::result_t out_reg;
    kcl_pkg::result_t step_res;
    logic [3:0]       max_attempts_reg;
    logic             advance;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_attempts_reg <= kcl_pkg::RESET_MAX_ATTEMPTS;
        end
        else if (cfg_wr_en)
        begin
            max_attempts_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            key_reg <= s_tdata[3:0];
        end
        if (advance)
        begin
            out_reg <= step_res;
        end
    end

    kcl_core #(
        .CODE_LENGTH (CODE_LENGTH)
    ) u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .step_en      (advance),
        .key          (key_reg),
        .max_attempts (max_attempts_reg),
        .res          (step_res)
    );

    // A confirmed entry either matches or it does not.
    `ASSERT_NEVER(a_unlock_xor_wrong, clk, rst_n, m_tvalid && m_tdata[0] && m_tdata[1])
    // Change mode is only entered on a mismatch and is then reported as active.
    `ASSERT_IMPLIES(a_enter_on_wrong, clk, rst_n, m_tvalid && m_tdata[2],
                    m_tdata[1] && m_tdata[7] && (m_tdata[6:4] == 3'd0))
    // Storing a new code leaves change mode with an empty entry.
    `ASSERT_IMPLIES(a_store_leaves_mode, clk, rst_n, m_tvalid && m_tdata[3],
                    !m_tdata[7] && (m_tdata[6:4] == 3'd0))
    // With no result waiting, the pipeline never refuses a key.
    `ASSERT_IMPLIES(a_ready_when_drained, clk, rst_n, !m_tvalid, s_tready)

endmodule

// ----- verif/tb_keypad_code_lock.sv -----
`timescale 1ns / 1ps

module tb_keypad_code_lock;

    localparam int CODE_LEN    = 6;
    localparam int STALL_LIMIT = 2000;

    logic       clk         = 1'b0;
    logic       rst_n       = 1'b0;
    logic       cfg_wr_en   = 1'b0;
    logic [3:0] cfg_wr_data = 4'd0;
    logic       s_tvalid    = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata     = 8'd0;   // [3:0] key_code, [7:4] zero
    logic       m_tvalid;
    logic       m_tready    = 1'b0;
    logic [7:0] m_tdata;              // [0] unlocked, [1] wrong_code, [2] change_entered,
                                      // [3] code_changed, [6:4] entry_length,
                                      // [7] in_change_mode

    keypad_code_lock #(
        .CODE_LENGTH(CODE_LEN)
    ) i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

    always #5 clk = ~clk;

    // Directed rows: key, whether the result is typed in here, then the result fields.
    typedef struct packed {
        kcl_pkg::key_t key;
        logic          chk;
        logic          unl;
        logic          wrong;
        logic          ent;
        logic          chg;
        logic [2:0]    len;
        logic          mode;
    } row_t;

    // The directed part runs with a failure limit of zero.
    row_t dir_rows [24] = '{
        //  key                chk unl wr ent chg len  mode
        '{kcl_pkg::KEY_HASH, 1, 0, 0, 0, 0, 3'd1, 0},  // hash on an empty entry is typed as a key
        '{kcl_pkg::KEY_HASH, 1, 0, 0, 0, 0, 3'd0, 0},  // and now deletes it
        '{kcl_pkg::KEY_STAR, 1, 0, 0, 0, 0, 3'd1, 0},  // star on a short entry is typed as a key
        '{4'd15,             0, 0, 0, 0, 0, 3'd0, 0},
        '{4'd13,             0, 0, 0, 0, 0, 3'd0, 0},
        '{4'd3,              0, 0, 0, 0, 0, 3'd0, 0},
        '{4'd7,              0, 0, 0, 0, 0, 3'd0, 0},
        '{4'd11,             0, 0, 0, 0, 0, 3'd0, 0},
        '{4'd0,              1, 0, 0, 0, 0, 3'd6, 0},  // buffer full: the key is dropped
        '{kcl_pkg::KEY_STAR, 1, 0, 1, 1, 0, 3'd0, 1},  // first miss enters change mode
        '{4'd15,             0, 0, 0, 0, 0, 3'd0, 0},
        '{4'd3,              0, 0, 0, 0, 0, 3'd0, 0},
        '{4'd7,              0, 0, 0, 0, 0, 3'd0, 0},
        '{4'd11,             0, 0, 0, 0, 0, 3'd0, 0},
        '{4'd9,              0, 0, 0, 0, 0, 3'd0, 0},
        '{kcl_pkg::KEY_STAR, 0, 0, 0, 0, 0, 3'd0, 0},
        '{kcl_pkg::KEY_STAR, 1, 0, 0, 0, 1, 3'd0, 0},  // new code stored, back to normal mode
        '{4'd15,             0, 0, 0, 0, 0, 3'd0, 0},
        '{4'd3,              0, 0, 0, 0, 0, 3'd0, 0},
        '{4'd7,              0, 0, 0, 0, 0, 3'd0, 0},
        '{4'd11,             0, 0, 0, 0, 0, 3'd0, 0},
        '{4'd9,              0, 0, 0, 0, 0, 3'd0, 0},
        '{kcl_pkg::KEY_STAR, 0, 0, 0, 0, 0, 3'd0, 0},
        '{kcl_pkg::KEY_STAR, 1, 1, 0, 0, 0, 3'd0, 0}   // the new code opens the lock
    };

    // Shadow state of the lock.
    kcl_pkg::key_t code_now [CODE_LEN];
    kcl_pkg::key_t typed    [CODE_LEN];
    logic [2:0]    typed_cnt;
    logic          awaiting_code;
    logic [3:0]    fail_cnt;
    logic [3:0]    attempts_lim;

    kcl_pkg::result_t pending_results [$];
    logic             cur_chk = 1'b0;
    kcl_pkg::result_t cur_res = '0;

    int  errors      = 0;
    int  keys_sent   = 0;
    int  cfg_writes  = 0;
    int  n_unlock    = 0;
    int  n_wrong     = 0;
    int  n_enter     = 0;
    int  n_changed   = 0;
    int  idle_cycles = 0;
    int  hold_len    = 0;
    bit  in_idle_on  = 1'b1;
    bit  out_idle_on = 1'b1;

    function automatic kcl_pkg::result_t predict_key_press(input kcl_pkg::key_t key);
        kcl_pkg::result_t r;
        logic             full;
        logic             same;
        r    = '0;
        full = (typed_cnt >= CODE_LEN);
        if (key == kcl_pkg::KEY_STAR && full)
        begin
            if (awaiting_code)
            begin
                code_now      = typed;
                awaiting_code = 1'b0;
                r.code_changed = 1'b1;
            end
            else
            begin
                same = 1'b1;
                for (int i = 0; i < CODE_LEN; i++)
                    if (typed[i] != code_now[i])
                        same = 1'b0;
                if (same)
                    r.unlocked = 1'b1;
                else
                begin
                    r.wrong_code = 1'b1;
                    fail_cnt     = fail_cnt + 4'd1;
                    // Greater-or-equal, so a limit lowered below the count still trips.
                    if (fail_cnt >= attempts_lim)
                    begin
                        awaiting_code    = 1'b1;
                        fail_cnt         = 4'd0;
                        r.change_entered = 1'b1;
                    end
                end
            end
            typed_cnt = 3'd0;
        end
        else if (key == kcl_pkg::KEY_HASH && typed_cnt != 3'd0)
            typed_cnt = typed_cnt - 3'd1;
        else if (!full)
        begin
            typed[typed_cnt] = key;
            typed_cnt        = typed_cnt + 3'd1;
        end
        r.entry_length   = typed_cnt;
        r.in_change_mode = awaiting_code;
        return r;
    endfunction

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
        end
    endfunction

    function automatic kcl_pkg::key_t plain_key();
        kcl_pkg::key_t k;
        do
            k = kcl_pkg::key_t'($urandom_range(0, 15));
        while (k == kcl_pkg::KEY_STAR || k == kcl_pkg::KEY_HASH);
        return k;
    endfunction

    // Called at a falling edge; returns at the falling edge after the request is taken.
    task automatic send_key(input kcl_pkg::key_t key, input logic chk = 1'b0,
                            input kcl_pkg::result_t res = '0);
        int gap;
        gap = in_idle_on ? $urandom_range(0, 12) : 0;
        if (gap != 0)
        begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        cur_chk  = chk;
        cur_res  = res;
        s_tdata  = {4'd0, key};
        s_tvalid = 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        @(negedge clk);
        keys_sent++;
    endtask

    task automatic write_limit(input logic [3:0] lim);
        s_tvalid = 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
        cfg_wr_data = lim;
        cfg_wr_en   = 1'b1;
        @(negedge clk);
        cfg_wr_en    = 1'b0;
        attempts_lim = lim;
        cfg_writes++;
    endtask

    // One attempt: mostly a cleared buffer, six keys and a confirm, sometimes noise.
    task automatic send_attempt(input int p_hit);
        kcl_pkg::key_t seq [CODE_LEN];
        int            roll;
        int            junk_at;
        roll = $urandom_range(0, 99);
        if (roll < 15)
        begin
            repeat ($urandom_range(1, 8)) send_key(kcl_pkg::key_t'($urandom_range(0, 15)));
            return;
        end
        while (typed_cnt != 3'd0)
            send_key(kcl_pkg::KEY_HASH);
        seq = code_now;
        if ($urandom_range(0, 99) >= p_hit)
        begin
            if ($urandom_range(0, 1) == 0)
                seq[$urandom_range(0, CODE_LEN - 1)] = plain_key();
            else
                foreach (seq[i])
                    seq[i] = plain_key();
        end
        junk_at = ($urandom_range(0, 3) == 0) ? $urandom_range(0, CODE_LEN - 1) : -1;
        for (int i = 0; i < CODE_LEN; i++)
        begin
            if (i == junk_at)
            begin
                send_key(plain_key());
                send_key(kcl_pkg::KEY_HASH);
            end
            send_key(seq[i]);
        end
        if ($urandom_range(0, 7) == 0)
            repeat ($urandom_range(1, 2)) send_key(plain_key());
        send_key(kcl_pkg::KEY_STAR);
    endtask

    task automatic run_phase(input logic [3:0] lim, input int n_keys, input int p_hit,
                             input bit idle_in, input bit idle_out, input int hold);
        int start;
        write_limit(lim);
        in_idle_on  = idle_in;
        out_idle_on = idle_out;
        hold_len    = hold;
        start       = keys_sent;
        while (keys_sent - start < n_keys)
            send_attempt(p_hit);
    endtask

    // Each accepted key request moves the shadow state on by one step.
    always @(posedge clk)
    begin
        kcl_pkg::result_t r;
        if (rst_n && s_tvalid && s_tready)
        begin
            r = predict_key_press(kcl_pkg::key_t'(s_tdata[3:0]));
            pending_results.push_back(cur_chk ? cur_res : r);
        end
    end

    always @(posedge clk)
    begin
        kcl_pkg::result_t got;
        kcl_pkg::result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = kcl_pkg::result_t'(m_tdata);
            if (pending_results.size() == 0)
            begin
                errors++;
                $display("%0t: result with nothing expected, expected none, got 0x%02h",
                         $time, m_tdata);
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("unlocked", want.unlocked, got.unlocked);
                check_field("wrong_code", want.wrong_code, got.wrong_code);
                check_field("change_entered", want.change_entered, got.change_entered);
                check_field("code_changed", want.code_changed, got.code_changed);
                check_field("entry_length", want.entry_length, got.entry_length);
                check_field("in_change_mode", want.in_change_mode, got.in_change_mode);
            end
            n_unlock  += got.unlocked;
            n_wrong   += got.wrong_code;
            n_enter   += got.change_entered;
            n_changed += got.code_changed;
        end
    end

    // Result side: a random stall before each result, plus one long hold-off on request.
    initial
    begin
        int stall;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            stall = out_idle_on ? $urandom_range(0, 12) : 0;
            if (hold_len != 0)
            begin
                stall    = hold_len;
                hold_len = 0;
            end
            if (stall != 0)
            begin
                m_tready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_tready = 1'b1;
            do
                @(posedge clk);
            while (!(m_tvalid && m_tready));
            @(negedge clk);
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
            $display("TB_ERROR");
            $finish;
        end
    end

    initial
    begin
        row_t             row;
        kcl_pkg::result_t res;
        // Reset code is the keys of the digits one to six.
        code_now      = '{4'd0, 4'd1, 4'd2, 4'd4, 4'd5, 4'd6};
        typed         = '{default: 4'd0};
        typed_cnt     = 3'd0;
        awaiting_code = 1'b0;
        fail_cnt      = 4'd0;
        attempts_lim  = kcl_pkg::RESET_MAX_ATTEMPTS;

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        write_limit(4'd0);
        foreach (dir_rows[i])
        begin
            row                = dir_rows[i];
            res                = '0;
            res.unlocked       = row.unl;
            res.wrong_code     = row.wrong;
            res.change_entered = row.ent;
            res.code_changed   = row.chg;
            res.entry_length   = row.len;
            res.in_change_mode = row.mode;
            send_key(row.key, row.chk, res);
        end

        run_phase(4'd15, 350, 10, 1'b1, 1'b1, 0);
        run_phase(4'd1, 150, 40, 1'b1, 1'b0, 0);
        run_phase(4'($urandom_range(2, 14)), 200, 40, 1'b0, 1'b0, 0);
        run_phase(4'd0, 100, 30, 1'b0, 1'b1, 0);
        // The long hold-off lets the lock fill up and push back on the key requests.
        run_phase(kcl_pkg::RESET_MAX_ATTEMPTS, 200, 40, 1'b1, 1'b1, 200);

        s_tvalid = 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("Sent %0d key presses under %0d failure-limit settings.", keys_sent, cfg_writes);
        $display("Seen %0d unlocks, %0d wrong codes, %0d change-mode entries, %0d new codes.",
                 n_unlock, n_wrong, n_enter, n_changed);
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+hdl
hdl/kcl_pkg.sv
hdl/kcl_core.sv
hdl/keypad_code_lock.sv
verif/tb_keypad_code_lock.sv
